>>> src/ssta_pkg.sv
// Shared types and constants of the sparse transpose scatter-accumulate core.
package ssta_pkg;

  // Accumulator store geometry
  localparam int unsigned Entries  = 1024;
  localparam int unsigned IdxW     = 10;
  localparam int unsigned MemDepth = (Entries < (1 << IdxW)) ? Entries : (1 << IdxW);
  localparam int unsigned AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;

  // Operand widths: Q16.16 operands, Q32.32 accumulator
  localparam int unsigned OpW  = 32;
  localparam int unsigned AccW = 64;

  localparam logic [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  // Command codes on the request channel
  typedef enum logic [1:0] {
    CmdLoad = 2'd0,
    CmdAcc  = 2'd1,
    CmdRead = 2'd2
  } cmd_e;

  // Operation carried by the execute stage
  typedef enum logic [1:0] {
    KindNone = 2'd0,
    KindLoad = 2'd1,
    KindAcc  = 2'd2,
    KindRead = 2'd3
  } kind_e;

  // Execute stage control
  typedef struct packed {
    kind_e            kind;
    logic [AddrW-1:0] addr;
  } stage_t;

endpackage

>>> src/ssta_req_if.sv
// Request channel: one command with its operands.
interface ssta_req_if;
  import ssta_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             cmd;
  logic [IdxW-1:0]        entry_index;
  logic signed [OpW-1:0]  mat_value;
  logic signed [OpW-1:0]  vec_value;
  logic signed [AccW-1:0] load_value;

  modport source (output valid, cmd, entry_index, mat_value, vec_value, load_value,
                  input ready);
  modport sink   (input valid, cmd, entry_index, mat_value, vec_value, load_value,
                  output ready);
endinterface

>>> src/ssta_rsp_if.sv
// Response channel: entry value after the command and the saturation flag.
interface ssta_rsp_if;
  import ssta_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [AccW-1:0] entry_value;
  logic                   overflow;

  modport source (output valid, entry_value, overflow, input ready);
  modport sink   (input valid, entry_value, overflow, output ready);
endinterface

>>> src/ssta_acc_store.sv
// Accumulator store: one write port, one registered read port with write bypass.
module ssta_acc_store (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [ssta_pkg::AddrW-1:0] rd_addr_i,
  output logic [ssta_pkg::AccW-1:0]  rd_data_o,
  input  logic                      wr_en_i,
  input  logic [ssta_pkg::AddrW-1:0] wr_addr_i,
  input  logic [ssta_pkg::AccW-1:0]  wr_data_i
);
  import ssta_pkg::*;

  logic [AccW-1:0] mem [MemDepth];
  logic [AccW-1:0] rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // Read port; a write to the same entry in the same cycle is passed through
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else begin
        rd_data_q <= mem[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> src/ssta_mac.sv
// Multiply-accumulate datapath: registered product of Q16.16 operands, saturating Q32.32 add.
module ssta_mac (
  input  logic                            clk_i,
  input  logic                            load_en_i,
  input  logic signed [ssta_pkg::OpW-1:0] mat_i,
  input  logic signed [ssta_pkg::OpW-1:0] vec_i,
  input  logic [ssta_pkg::AccW-1:0]       acc_i,
  output logic [ssta_pkg::AccW-1:0]       sum_o,
  output logic                            ovf_o
);
  import ssta_pkg::*;

  logic signed [AccW-1:0] prod_full;
  logic [AccW-1:0]        prod_q;
  logic [AccW-1:0]        raw_sum;

  // Full-width signed product, exact in Q32.32
  assign prod_full = mat_i * vec_i;

  always_ff @(posedge clk_i) begin
    if (load_en_i) begin
      prod_q <= prod_full;
    end
  end

  // Add with saturation on signed overflow
  always_comb begin
    raw_sum = acc_i + prod_q;
    ovf_o   = (acc_i[AccW-1] == prod_q[AccW-1]) && (raw_sum[AccW-1] != acc_i[AccW-1]);
    if (ovf_o) begin
      sum_o = acc_i[AccW-1] ? AccMin : AccMax;
    end else begin
      sum_o = raw_sum;
    end
  end

endmodule

>>> src/sparse_transpose_scatter_accumulate_core.sv
// Top level of the sparse transpose scatter-accumulate core.
//
// Usage: requests arrive on req_i (valid/ready). cmd selects load, accumulate
// or read of one accumulator entry; accumulate adds mat_value * vec_value
// (Q16.16 each, exact Q32.32 product) to the entry named by entry_index with
// saturation. Every request gives exactly one response on rsp_o carrying the
// entry value after the command and the overflow flag. Indexes at or above
// the store depth and the unused command leave the store alone and answer 0.
// An accepted request moves into the execute stage and then into the response
// register. Throughput: one request per cycle while rsp_o.ready stays high.
// Stage one reads the store and forms the product; stage two adds, writes back
// and fills the response register. A write back to the entry read in the same
// cycle is bypassed in the store.
// Reset clears the pipeline valids and the execute stage control only; entries
// are undefined until loaded. When the receiver stalls, the response register
// holds, the execute stage holds behind it and req_i.ready falls once both are full.
module sparse_transpose_scatter_accumulate_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  ssta_req_if.sink    req_i,
  ssta_rsp_if.source  rsp_o
);
  import ssta_pkg::*;

  logic             accept;
  logic             out_free;
  logic             s1_adv;
  logic             in_range;
  stage_t           s1_d;
  stage_t           s1_q;
  logic             s1_valid_q;
  logic [AccW-1:0]  load_q;
  logic [AccW-1:0]  rd_data;
  logic [AccW-1:0]  sum;
  logic             sum_ovf;
  logic [AccW-1:0]  res_value;
  logic             res_ovf;
  logic             wr_en;
  logic             out_valid_q;
  logic [AccW-1:0]  out_value_q;
  logic             out_ovf_q;

  // Handshake
  assign out_free     = !out_valid_q || rsp_o.ready;
  assign s1_adv       = s1_valid_q && out_free;
  assign req_i.ready  = !s1_valid_q || out_free;
  assign accept       = req_i.valid && req_i.ready;
  assign in_range     = ({{(32 - IdxW){1'b0}}, req_i.entry_index} < 32'(Entries));

  // Decode the incoming command
  always_comb begin
    s1_d.addr = req_i.entry_index[AddrW-1:0];
    s1_d.kind = KindNone;
    if (in_range) begin
      unique case (cmd_e'(req_i.cmd))
        CmdLoad: s1_d.kind = KindLoad;
        CmdAcc:  s1_d.kind = KindAcc;
        CmdRead: s1_d.kind = KindRead;
        default: s1_d.kind = KindNone;
      endcase
    end
  end

  // Execute stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_q       <= '{kind: KindNone, addr: '0};
    end else if (accept) begin
      s1_valid_q <= 1'b1;
      s1_q       <= s1_d;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  // Load operand
  always_ff @(posedge clk_i) begin
    if (accept) begin
      load_q <= req_i.load_value;
    end
  end

  ssta_acc_store u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept && (s1_d.kind != KindNone)),
    .rd_addr_i (s1_d.addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_q.addr),
    .wr_data_i (res_value)
  );

  ssta_mac u_mac (
    .clk_i     (clk_i),
    .load_en_i (accept),
    .mat_i     (req_i.mat_value),
    .vec_i     (req_i.vec_value),
    .acc_i     (rd_data),
    .sum_o     (sum),
    .ovf_o     (sum_ovf)
  );

  // Result select
  always_comb begin
    res_value = '0;
    res_ovf   = 1'b0;
    unique case (s1_q.kind)
      KindLoad: res_value = load_q;
      KindAcc: begin
        res_value = sum;
        res_ovf   = sum_ovf;
      end
      KindRead: res_value = rd_data;
      KindNone: res_value = '0;
      default:  res_value = '0;
    endcase
  end

  assign wr_en = s1_adv && ((s1_q.kind == KindLoad) || (s1_q.kind == KindAcc));

  // Response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_value_q <= res_value;
      out_ovf_q   <= res_ovf;
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.entry_value = out_value_q;
  assign rsp_o.overflow    = out_ovf_q;

endmodule
